// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clock and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property that must hold at every edge
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== sv/rswr_pkg.sv =====
// ----------------------------------------------------------------------------
// rswr_pkg
// shared constants and types of the sampler without replacement
// ----------------------------------------------------------------------------
package rswr_pkg;

   localparam int MAX_POPULATION_DEFAULT = 1024;

   localparam int ENTRY_W = 10;
   localparam int COUNT_W = 11;
   localparam int WORD_W  = 32;

   localparam logic OP_RESTART = 1'b0;
   localparam logic OP_DRAW    = 1'b1;

   localparam logic CSR_POPULATION   = 1'b0;
   localparam logic CSR_SAMPLE_COUNT = 1'b1;

   localparam logic [COUNT_W-1:0] POPULATION_RESET   = 11'd1024;
   localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 11'd1;

   typedef struct packed {
      logic               start;
      logic [WORD_W-1:0]  dividend;
      logic [COUNT_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] remainder;
   } mod_rsp_type;

endpackage

// ===== sv/rswr_ram.sv =====
// ----------------------------------------------------------------------------
// rswr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rswr_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rswr_mod.sv =====
// ----------------------------------------------------------------------------
// rswr_mod
// bit-serial restoring modulo of a 32-bit word by an 11-bit count
// ----------------------------------------------------------------------------
module rswr_mod (
   input  logic                 clock,
   input  logic                 reset,
   input  rswr_pkg::mod_req_type req,
   output rswr_pkg::mod_rsp_type rsp
);

   localparam int CNT_W = $clog2(rswr_pkg::WORD_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [rswr_pkg::WORD_W-1:0]   word_ff, word_in;
   logic [rswr_pkg::COUNT_W-1:0]  divisor_ff, divisor_in;
   logic [rswr_pkg::COUNT_W-1:0]  rem_ff, rem_in;
   logic [rswr_pkg::COUNT_W:0]    trial;
   logic [rswr_pkg::COUNT_W:0]    diff;

   assign trial = {rem_ff, word_ff[rswr_pkg::WORD_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      word_in    = word_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         word_in    = req.dividend;
         divisor_in = req.divisor;
         rem_in     = '0;
      end else if (busy_ff) begin
         word_in  = {word_ff[rswr_pkg::WORD_W-2:0], 1'b0};
         count_in = count_ff + CNT_W'(1);
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = diff[rswr_pkg::COUNT_W-1:0];
         end else begin
            rem_in = trial[rswr_pkg::COUNT_W-1:0];
         end
         if (count_ff == CNT_W'(rswr_pkg::WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      word_ff    <= word_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== sv/random_sample_without_replacement.sv =====
// ----------------------------------------------------------------------------
// random_sample_without_replacement
// draws distinct indices by a partial fisher-yates shuffle over a ram table
// ----------------------------------------------------------------------------
// Usage: a word is taken on the rising edge where start is high and busy is
// low. req_operation selects restart (refill table, reload the live count
// from population) or draw (req_rand_word picks a live slot).
// A restart gives no result; it sweeps the index table with the identity,
// one entry a cycle. A draw reduces the random word modulo the live count
// in a bit-serial unit, then reads the slot and the last live entry and
// writes them back swapped over the table's read and write ports.
// rsp_valid pulses for one cycle once the swap is written; an exhausted
// draw is answered from the idle state, without the modulo unit. The
// receiver cannot stall: each result shows for exactly one cycle. No new
// word is taken until a draw has passed the modulo unit and the four table
// accesses. Configuration through csr_we, csr_index and csr_wdata is for
// the user to write only while busy is low; the block does not enforce it.
// sample_count acts at once, population at the next restart. Reset loads
// the register defaults and runs a restart's table sweep before busy falls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module random_sample_without_replacement #(
   parameter int MAX_POPULATION = rswr_pkg::MAX_POPULATION_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_operation,
   input  logic [rswr_pkg::WORD_W-1:0]    req_rand_word,
   output logic                           rsp_valid,
   output logic [rswr_pkg::ENTRY_W-1:0]   rsp_sampled_index,
   output logic                           rsp_last_of_run,
   output logic                           rsp_exhausted,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [rswr_pkg::COUNT_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(MAX_POPULATION);
   localparam int CW = rswr_pkg::COUNT_W;
   localparam int EW = rswr_pkg::ENTRY_W;
   localparam int CountMax = (1 << CW) - 1;
   localparam int RemCapInt = (MAX_POPULATION > CountMax) ? CountMax : MAX_POPULATION;
   localparam int RemResetInt =
      (MAX_POPULATION > int'(rswr_pkg::POPULATION_RESET)) ?
      int'(rswr_pkg::POPULATION_RESET) : MAX_POPULATION;
   localparam logic [CW-1:0] RemCap   = CW'(RemCapInt);
   localparam logic [CW-1:0] RemReset = CW'(RemResetInt);
   localparam logic [AW-1:0] LastAddr = AW'(MAX_POPULATION - 1);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_DIV     = 3'd2;
   localparam logic [2:0] S_RD_SLOT = 3'd3;
   localparam logic [2:0] S_RD_LAST = 3'd4;
   localparam logic [2:0] S_WR_SLOT = 3'd5;
   localparam logic [2:0] S_WR_LAST = 3'd6;

   logic [2:0]     state_ff, state_in;
   logic [AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0]  population_ff, population_in;
   logic [CW-1:0]  sample_count_ff, sample_count_in;
   logic [CW-1:0]  remaining_ff, remaining_in;
   logic [CW-1:0]  draws_done_ff, draws_done_in;
   logic [CW-1:0]  slot_ff, slot_in;
   logic [EW-1:0]  picked_ff, picked_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0]  rsp_index_ff, rsp_index_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_exh_ff, rsp_exh_in;

   logic [CW-1:0]  last_slot;
   logic [CW-1:0]  draws_next;
   logic           accept;
   logic           mem_we;
   logic [AW-1:0]  mem_wr_addr;
   logic [EW-1:0]  mem_wr_data;
   logic [AW-1:0]  mem_rd_addr;
   logic [EW-1:0]  mem_rd_data;

   rswr_pkg::mod_req_type mod_req;
   rswr_pkg::mod_rsp_type mod_rsp;

   assign accept     = start && (state_ff == S_IDLE);
   assign last_slot  = remaining_ff - CW'(1);
   assign draws_next = (draws_done_ff == CW'(CountMax)) ? draws_done_ff
                                                         : draws_done_ff + CW'(1);

   assign mod_req.start    = accept && (req_operation == rswr_pkg::OP_DRAW)
                             && (remaining_ff != '0);
   assign mod_req.dividend = req_rand_word;
   assign mod_req.divisor  = remaining_ff;

   rswr_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   rswr_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_POPULATION)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      mem_we      = 1'b0;
      mem_wr_addr = clr_cnt_ff;
      mem_wr_data = EW'(clr_cnt_ff);
      mem_rd_addr = (state_ff == S_RD_LAST) ? AW'(last_slot) : AW'(slot_ff);
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
         end
         S_WR_SLOT: begin
            mem_we      = 1'b1;
            mem_wr_addr = AW'(slot_ff);
            mem_wr_data = mem_rd_data;
         end
         S_WR_LAST: begin
            mem_we      = 1'b1;
            mem_wr_addr = AW'(last_slot);
            mem_wr_data = picked_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      clr_cnt_in      = clr_cnt_ff;
      population_in   = population_ff;
      sample_count_in = sample_count_ff;
      remaining_in    = remaining_ff;
      draws_done_in   = draws_done_ff;
      slot_in         = slot_ff;
      picked_in       = picked_ff;
      rsp_valid_in    = 1'b0;
      rsp_index_in    = rsp_index_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_exh_in      = rsp_exh_ff;

      if (csr_we) begin
         case (csr_index)
            rswr_pkg::CSR_POPULATION:   population_in   = csr_wdata;
            rswr_pkg::CSR_SAMPLE_COUNT: sample_count_in = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == LastAddr) begin
               clr_cnt_in = '0;
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_operation == rswr_pkg::OP_RESTART) begin
                  remaining_in  = (population_ff > RemCap) ? RemCap : population_ff;
                  draws_done_in = '0;
                  clr_cnt_in    = '0;
                  state_in      = S_CLEAR;
               end else if (remaining_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = '0;
                  rsp_last_in  = 1'b0;
                  rsp_exh_in   = 1'b1;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (mod_rsp.done) begin
               slot_in  = mod_rsp.remainder;
               state_in = S_RD_SLOT;
            end
         end
         S_RD_SLOT: begin
            state_in = S_RD_LAST;
         end
         S_RD_LAST: begin
            picked_in = mem_rd_data;
            state_in  = S_WR_SLOT;
         end
         S_WR_SLOT: begin
            state_in = S_WR_LAST;
         end
         S_WR_LAST: begin
            remaining_in  = last_slot;
            draws_done_in = draws_next;
            rsp_valid_in  = 1'b1;
            rsp_index_in  = picked_ff;
            rsp_last_in   = (draws_next == sample_count_ff);
            rsp_exh_in    = 1'b0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_cnt_ff      <= '0;
         population_ff   <= rswr_pkg::POPULATION_RESET;
         sample_count_ff <= rswr_pkg::SAMPLE_COUNT_RESET;
         remaining_ff    <= RemReset;
         draws_done_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_cnt_ff      <= clr_cnt_in;
         population_ff   <= population_in;
         sample_count_ff <= sample_count_in;
         remaining_ff    <= remaining_in;
         draws_done_ff   <= draws_done_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      slot_ff      <= slot_in;
      picked_ff    <= picked_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_exh_ff   <= rsp_exh_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sampled_index = rsp_index_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_exhausted     = rsp_exh_ff;

   `ASSERT_CLK(a_slot_live,
      (state_ff == S_RD_SLOT) |-> (slot_ff < remaining_ff),
      "slot out of live range")
   `ASSERT_CLK(a_mod_range,
      (state_ff == S_DIV && mod_rsp.done) |-> (mod_rsp.remainder < remaining_ff),
      "modulo result too large")
   `ASSERT_CLK(a_shrink,
      (state_ff == S_WR_LAST) |=> (remaining_ff == $past(last_slot)),
      "live count did not shrink by one")
   `ASSERT_CLK(a_draw_rsp,
      (rsp_valid_ff && !rsp_exh_ff) |-> $past(state_ff == S_WR_LAST),
      "draw result without swap write-back")
   `ASSERT_NEVER(a_exh_live,
      rsp_valid_ff && rsp_exh_ff && $past(remaining_ff != '0),
      "exhausted flagged with entries left")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// testbench of the sampler without replacement
// ----------------------------------------------------------------------------
// Drives restart and draw words through the start/busy handshake and writes
// the population and sample count registers between phases, once the block
// has gone quiet. A scoreboard keeps its own copy of the index table, the
// live count and the draw count, predicts each draw from the random word,
// and compares every strobed result field by field in order. A short
// directed part covers the reset state, the one-entry table, the empty
// table, a zero and an oversized population, and a zero and a maximum
// sample count; then random phases of mostly full runs (restart followed by
// enough draws to empty the table) with some stray draws and early
// restarts, sender gaps at random, and one long phase with no gaps.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRY_W = rswr_pkg::ENTRY_W;
   localparam int COUNT_W = rswr_pkg::COUNT_W;
   localparam int WORD_W  = rswr_pkg::WORD_W;

   localparam logic OP_RESTART       = rswr_pkg::OP_RESTART;
   localparam logic OP_DRAW          = rswr_pkg::OP_DRAW;
   localparam logic CSR_POPULATION   = rswr_pkg::CSR_POPULATION;
   localparam logic CSR_SAMPLE_COUNT = rswr_pkg::CSR_SAMPLE_COUNT;

   localparam logic [COUNT_W-1:0] POPULATION_RESET   = rswr_pkg::POPULATION_RESET;
   localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = rswr_pkg::SAMPLE_COUNT_RESET;

   localparam int MAX_POP       = rswr_pkg::MAX_POPULATION_DEFAULT;
   localparam int SETTLE_CYCLES = MAX_POP + 64;
   localparam int LIMIT_CYCLES  = 4_000_000;
   localparam int TOTAL_ITEMS   = 920;

   typedef struct packed {
      logic [ENTRY_W-1:0] sampled_index;
      logic               last_of_run;
      logic               exhausted;
   } draw_word_type;

   class draw_scoreboard;
      bit [ENTRY_W-1:0] index_table [MAX_POP];
      bit [COUNT_W-1:0] live_count;
      bit [COUNT_W-1:0] draw_count;
      bit [COUNT_W-1:0] population;
      bit [COUNT_W-1:0] sample_count;
      draw_word_type    pending_draws [$];
      int               errors;
      int               restarts;
      int               draws_checked;
      int               exhausted_seen;
      int               run_ends_seen;

      function new();
         population   = POPULATION_RESET;
         sample_count = SAMPLE_COUNT_RESET;
         refill_table();
      endfunction

      function void refill_table();
         for (int i = 0; i < MAX_POP; i++) begin
            index_table[i] = i[ENTRY_W-1:0];
         end
         live_count = (population > MAX_POP) ? COUNT_W'(MAX_POP) : population;
         draw_count = '0;
      endfunction

      function void write_reg(logic index, logic [COUNT_W-1:0] value);
         if (index == CSR_POPULATION) begin
            population = value;
         end else begin
            sample_count = value;
         end
      endfunction

      function void note_item(logic operation, logic [WORD_W-1:0] rand_word);
         bit [WORD_W-1:0]  slot;
         bit [COUNT_W-1:0] last;
         bit [ENTRY_W-1:0] picked;
         draw_word_type    expected;
         if (operation == OP_RESTART) begin
            refill_table();
            restarts++;
            return;
         end
         if (live_count == 0 || live_count > MAX_POP) begin
            expected = '{sampled_index: '0, last_of_run: 1'b0, exhausted: 1'b1};
            pending_draws.push_back(expected);
            return;
         end
         slot   = rand_word % {{(WORD_W-COUNT_W){1'b0}}, live_count};
         last   = live_count - 1'b1;
         picked = index_table[slot];
         index_table[slot] = index_table[last];
         index_table[last] = picked;
         live_count = last;
         if (draw_count != '1) begin
            draw_count++;
         end
         expected = '{sampled_index: picked, last_of_run: (draw_count == sample_count),
                      exhausted: 1'b0};
         pending_draws.push_back(expected);
      endfunction

      function void check_draw(logic [ENTRY_W-1:0] sampled_index, logic last_of_run,
                               logic exhausted);
         draw_word_type expected;
         if (pending_draws.size() == 0) begin
            $error("unexpected result: sampled_index %0d last_of_run %0b exhausted %0b",
                   sampled_index, last_of_run, exhausted);
            errors++;
            return;
         end
         expected = pending_draws.pop_front();
         draws_checked++;
         if (expected.exhausted) exhausted_seen++;
         if (expected.last_of_run) run_ends_seen++;
         if (sampled_index !== expected.sampled_index) begin
            $error("sampled_index: expected %0d, actual %0d",
                   expected.sampled_index, sampled_index);
            errors++;
         end
         if (last_of_run !== expected.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", expected.last_of_run, last_of_run);
            errors++;
         end
         if (exhausted !== expected.exhausted) begin
            $error("exhausted: expected %0b, actual %0b", expected.exhausted, exhausted);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_operation = OP_RESTART;
   logic [WORD_W-1:0]  req_rand_word = '0;
   logic               rsp_valid;
   logic [ENTRY_W-1:0] rsp_sampled_index;
   logic               rsp_last_of_run;
   logic               rsp_exhausted;
   logic               csr_we = 1'b0;
   logic               csr_index = CSR_POPULATION;
   logic [COUNT_W-1:0] csr_wdata = '0;

   draw_scoreboard sb = new();
   int  cycle_count = 0;
   int  sent_items = 0;
   int  settings_used = 0;
   bit  gaps_on = 1'b1;

   random_sample_without_replacement #(
      .MAX_POPULATION(MAX_POP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_rand_word(req_rand_word),
      .rsp_valid(rsp_valid),
      .rsp_sampled_index(rsp_sampled_index),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_exhausted(rsp_exhausted),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            sb.check_draw(rsp_sampled_index, rsp_last_of_run, rsp_exhausted);
         end
         if (csr_we) begin
            sb.write_reg(csr_index, csr_wdata);
         end
         if (start && busy === 1'b0) begin
            sb.note_item(req_operation, req_rand_word);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, sb.pending_draws.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_item(logic operation, logic [WORD_W-1:0] rand_word);
      start         <= 1'b1;
      req_operation <= operation;
      req_rand_word <= rand_word;
      do @(posedge clock); while (busy !== 1'b0);
      sent_items++;
   endtask

   task automatic sender_gap();
      if (gaps_on && $urandom_range(0, 99) < 27) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 45)) @(posedge clock);
      end
   endtask

   // wait for the last result, then for a restart sweep that gives none
   task automatic settle();
      start <= 1'b0;
      while (sb.pending_draws.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(logic [COUNT_W-1:0] pop, logic [COUNT_W-1:0] count);
      csr_we    <= 1'b1;
      csr_index <= CSR_POPULATION;
      csr_wdata <= pop;
      @(posedge clock);
      csr_index <= CSR_SAMPLE_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return $urandom;
   endfunction

   task automatic send_draws(int n);
      for (int i = 0; i < n; i++) begin
         send_item(OP_DRAW, pick_word());
         sender_gap();
      end
   endtask

   task automatic run_phase(int phase);
      int pop;
      int count;
      int live;
      int phase_items;
      int n_draws;
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) pop = 0;
      else if (r < 16) pop = $urandom_range(MAX_POP + 1, 2047);
      else if (r < 24) pop = $urandom_range(200, MAX_POP);
      else pop = $urandom_range(1, 48);
      if (phase == 3) pop = $urandom_range(2, 24);
      live = (pop > MAX_POP) ? MAX_POP : pop;
      r = $urandom_range(0, 99);
      if (r < 10) count = 0;
      else if (r < 18) count = 2047;
      else count = $urandom_range(1, live + 2);
      phase_items = (phase == 3) ? 220 : $urandom_range(40, 110);
      gaps_on = (phase != 3);
      settle();
      write_settings(pop[COUNT_W-1:0], count[COUNT_W-1:0]);
      while (phase_items > 0 && sent_items < TOTAL_ITEMS) begin
         // most runs are a restart followed by draws; a few carry on the old run
         if ($urandom_range(0, 99) < 88) begin
            send_item(OP_RESTART, $urandom);
            sender_gap();
            phase_items--;
         end
         if (live == 0) n_draws = $urandom_range(1, 3);
         else if (live > 60) n_draws = $urandom_range(20, 60);
         else if ($urandom_range(0, 99) < 75) n_draws = live + $urandom_range(0, 3);
         else n_draws = $urandom_range(1, live + 3);
         send_draws(n_draws);
         phase_items -= n_draws;
      end
   endtask

   initial begin
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (busy !== 1'b0);

      // reset state: full table, first draw ends the run
      send_item(OP_DRAW, '0);
      send_item(OP_DRAW, '1);
      send_item(OP_DRAW, 32'hAAAA_AAAA);
      send_item(OP_DRAW, 32'h5555_5555);

      // one entry: slot equals last, then empty table
      settle();
      write_settings(11'd1, 11'd1);
      send_item(OP_RESTART, '1);
      send_item(OP_DRAW, 32'hFFFF_FFFE);
      send_item(OP_DRAW, 32'h1234_5678);
      send_item(OP_RESTART, '0);
      send_item(OP_DRAW, '1);

      // population zero
      settle();
      write_settings(11'd0, 11'd1);
      send_item(OP_RESTART, '0);
      send_item(OP_DRAW, '1);

      // oversized population saturates, sample count zero marks nothing
      settle();
      write_settings(11'd2047, 11'd0);
      send_item(OP_RESTART, '0);
      send_item(OP_DRAW, '1);
      send_item(OP_DRAW, '0);

      // two entries drawn past the end with the largest sample count
      settle();
      write_settings(11'd2, 11'd2047);
      send_item(OP_RESTART, '0);
      send_item(OP_DRAW, '0);
      send_item(OP_DRAW, '1);
      send_item(OP_DRAW, 32'h8000_0001);
      send_item(OP_DRAW, 32'h7FFF_FFFF);

      phase = 0;
      while (sent_items < TOTAL_ITEMS) begin
         phase++;
         run_phase(phase);
      end

      start <= 1'b0;
      while (sb.pending_draws.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("covered %0d restarts and %0d draws over %0d register settings",
               sb.restarts, sb.draws_checked, settings_used);
      $display("draws on an empty table %0d, draws that ended a run %0d",
               sb.exhausted_seen, sb.run_ends_seen);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
